>>> rtl/ked_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ked_pkg: shared types and constants for the Kruskal edge acceptor
// Table geometry, field widths, sequencer states and inter-module structs.
// ============================================================================
package ked_pkg;

    // Node index width follows the 10-bit endpoint fields
    localparam int NODE_BITS      = 10;
    localparam int MAX_NODES      = 1 << NODE_BITS;
    localparam int CNT_BITS       = NODE_BITS + 1;
    localparam int WEIGHT_BITS    = 31;
    localparam int TOTAL_BITS     = 41;
    localparam int RANK_BITS      = 4;
    localparam int CFG_BITS       = 11;

    localparam logic [RANK_BITS-1:0]  RANK_MAX  = {RANK_BITS{1'b1}};
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
    localparam logic [NODE_BITS-1:0]  LAST_NODE = NODE_BITS'(MAX_NODES - 1);
    localparam logic [CNT_BITS-1:0]   NODES_RST = CNT_BITS'(MAX_NODES);

    // Stream packing
    localparam int IN_TDATA_BITS  = 56;
    localparam int OUT_TDATA_BITS = 56;
    localparam int OUT_TUSER_BITS = 3;

    // One table entry: rank above parent
    typedef struct packed {
        logic [RANK_BITS-1:0] rank;
        logic [NODE_BITS-1:0] parent;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND,
        ST_COMP,
        ST_UNION,
        ST_RANK,
        ST_RESULT
    } seq_state_t;

    // Sequencer to tally
    typedef struct packed {
        logic                   take;
        logic                   load;
        logic                   acc;
        logic                   last;
        logic [WEIGHT_BITS-1:0] weight;
    } tally_cmd_t;

    // Tally to sequencer
    typedef struct packed {
        logic [CNT_BITS-1:0] node_count;
        logic                done;
        logic                out_free;
    } tally_stat_t;

endpackage

>>> rtl/ked_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// ked_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module ked_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/ked_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// ked_seq: disjoint-set sequencer
// Clears the table, walks both parent chains, compresses the paths and
// performs the union by rank, all through the single table memory.
// ============================================================================
module ked_seq
    import ked_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [NODE_BITS-1:0]   edge_from,
    input  logic [NODE_BITS-1:0]   edge_to,
    input  logic [WEIGHT_BITS-1:0] edge_weight,
    input  logic                   last_edge,
    input  tally_stat_t            stat,
    output tally_cmd_t             cmd,
    output logic                   ram_we,
    output logic [NODE_BITS-1:0]   ram_waddr,
    output entry_t                 ram_wdata,
    output logic                   ram_re,
    output logic [NODE_BITS-1:0]   ram_raddr,
    input  entry_t                 ram_rdata
);

    seq_state_t state_reg, state_next;

    logic [NODE_BITS-1:0]   clr_reg;
    logic                   phase_reg;     // 0: endpoint a, 1: endpoint b
    logic [NODE_BITS-1:0]   cur_reg;
    logic [NODE_BITS-1:0]   a_reg;
    logic [NODE_BITS-1:0]   b_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic                   last_reg;
    logic                   acc_reg;
    logic [NODE_BITS-1:0]   root_a_reg;
    logic [NODE_BITS-1:0]   root_b_reg;
    logic [RANK_BITS-1:0]   rank_a_reg;
    logic [RANK_BITS-1:0]   rank_b_reg;

    logic                   edge_ok;
    logic                   at_root;
    logic                   comp_done;
    logic                   roots_differ;
    logic                   rank_a_gt;
    logic                   rank_bump;
    logic [NODE_BITS-1:0]   root_cur;
    logic [NODE_BITS-1:0]   start_cur;

    // Decode helpers
    always_comb
    begin
        edge_ok      = !stat.done
                       && ({1'b0, edge_from} < stat.node_count)
                       && ({1'b0, edge_to} < stat.node_count);
        root_cur     = phase_reg ? root_b_reg : root_a_reg;
        start_cur    = phase_reg ? b_reg : a_reg;
        at_root      = (ram_rdata.parent == cur_reg);
        comp_done    = (cur_reg == root_cur);
        roots_differ = (root_a_reg != root_b_reg);
        rank_a_gt    = (rank_a_reg > rank_b_reg);
        rank_bump    = (rank_a_reg == rank_b_reg) && (rank_b_reg < RANK_MAX);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_NODE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = edge_ok ? ST_FIND : ST_RESULT;
                end
            end
            ST_FIND:
            begin
                if (at_root)
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                if (comp_done)
                begin
                    state_next = phase_reg ? ST_UNION : ST_FIND;
                end
            end
            ST_UNION:
            begin
                if (roots_differ && !rank_a_gt && rank_bump)
                begin
                    state_next = ST_RANK;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RANK:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        // A node_count write restarts the table sweep
        if (cfg_wr_en)
        begin
            state_next = ST_CLEAR;
        end
    end

    // Outputs: memory access, handshake and tally commands
    always_comb
    begin
        s_tready   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg;
        ram_wdata  = '{rank: ram_rdata.rank, parent: root_cur};
        ram_re     = 1'b0;
        ram_raddr  = ram_rdata.parent;
        cmd.take   = 1'b0;
        cmd.load   = 1'b0;
        cmd.acc    = acc_reg;
        cmd.last   = last_reg;
        cmd.weight = w_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '{rank: '0, parent: clr_reg};
            end
            ST_IDLE:
            begin
                s_tready  = !cfg_wr_en;
                ram_re    = s_tvalid;
                ram_raddr = edge_from;
            end
            ST_FIND:
            begin
                ram_re = 1'b1;
                if (at_root)
                begin
                    ram_raddr = start_cur;
                end
            end
            ST_COMP:
            begin
                if (comp_done)
                begin
                    ram_re    = !phase_reg;
                    ram_raddr = b_reg;
                end
                else
                begin
                    // point this node straight at the root, fetch the next one
                    ram_we = 1'b1;
                    ram_re = 1'b1;
                end
            end
            ST_UNION:
            begin
                cmd.take = roots_differ;
                ram_we   = roots_differ;
                if (rank_a_gt)
                begin
                    ram_waddr = root_b_reg;
                    ram_wdata = '{rank: rank_b_reg, parent: root_a_reg};
                end
                else
                begin
                    ram_waddr = root_a_reg;
                    ram_wdata = '{rank: rank_a_reg, parent: root_b_reg};
                end
            end
            ST_RANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = root_b_reg;
                ram_wdata = '{rank: rank_b_reg + 1'b1, parent: root_b_reg};
            end
            ST_RESULT:
            begin
                cmd.load = stat.out_free;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                clr_reg <= '0;
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_IDLE)
            begin
                phase_reg <= 1'b0;
            end
            else if (state_reg == ST_COMP && comp_done)
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    // Edge and walk registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    a_reg    <= edge_from;
                    b_reg    <= edge_to;
                    w_reg    <= edge_weight;
                    last_reg <= last_edge;
                    cur_reg  <= edge_from;
                    acc_reg  <= 1'b0;
                end
            end
            ST_FIND:
            begin
                if (at_root)
                begin
                    if (phase_reg)
                    begin
                        root_b_reg <= cur_reg;
                        rank_b_reg <= ram_rdata.rank;
                    end
                    else
                    begin
                        root_a_reg <= cur_reg;
                        rank_a_reg <= ram_rdata.rank;
                    end
                    cur_reg <= start_cur;
                end
                else
                begin
                    cur_reg <= ram_rdata.parent;
                end
            end
            ST_COMP:
            begin
                if (comp_done)
                begin
                    cur_reg <= b_reg;
                end
                else
                begin
                    cur_reg <= ram_rdata.parent;
                end
            end
            ST_UNION:
            begin
                acc_reg <= roots_differ;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

>>> rtl/ked_tally.sv
`timescale 1ns / 1ps
// ============================================================================
// ked_tally: node count, running totals and result register
// Holds node_count, the saturating weight sum and edge count, and the
// output register that feeds the result stream.
// ============================================================================
module ked_tally
    import ked_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_BITS-1:0]       cfg_wr_data,
    input  tally_cmd_t                cmd,
    output tally_stat_t               stat,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [TOTAL_BITS-1:0]     total_weight,
    output logic [NODE_BITS-1:0]      edges_taken,
    output logic                      accepted,
    output logic                      complete,
    output logic                      impossible
);

    logic [CNT_BITS-1:0]   nc_reg;
    logic [CNT_BITS-1:0]   nc_next;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [NODE_BITS-1:0]  count_reg;
    logic [TOTAL_BITS:0]   sum;
    logic                  done;
    logic                  m_tvalid_reg;
    logic [TOTAL_BITS-1:0] total_out_reg;
    logic [NODE_BITS-1:0]  count_out_reg;
    logic                  acc_out_reg;
    logic                  comp_out_reg;
    logic                  imp_out_reg;

    // Clamp the written node count to 1..MAX_NODES
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            nc_next = CNT_BITS'(1);
        end
        else if (cfg_wr_data > NODES_RST)
        begin
            nc_next = NODES_RST;
        end
        else
        begin
            nc_next = cfg_wr_data;
        end
    end

    // Completion and saturating add
    always_comb
    begin
        done           = (({1'b0, count_reg} + 1'b1) == nc_reg);
        sum            = {1'b0, total_reg} + (TOTAL_BITS + 1)'(cmd.weight);
        stat.node_count = nc_reg;
        stat.done       = done;
        stat.out_free   = !m_tvalid_reg || m_tready;
    end

    // Running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg    <= NODES_RST;
            total_reg <= '0;
            count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            nc_reg    <= nc_next;
            total_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.take)
        begin
            total_reg <= sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
            count_reg <= count_reg + 1'b1;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            total_out_reg <= total_reg;
            count_out_reg <= count_reg;
            acc_out_reg   <= cmd.acc;
            comp_out_reg  <= done;
            imp_out_reg   <= cmd.last && !done;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign total_weight = total_out_reg;
    assign edges_taken  = count_out_reg;
    assign accepted     = acc_out_reg;
    assign complete     = comp_out_reg;
    assign impossible   = imp_out_reg;

endmodule

>>> rtl/kruskal_edge_acceptor_top.sv
`timescale 1ns / 1ps
// ============================================================================
// kruskal_edge_acceptor_top: Kruskal minimum spanning tree edge acceptor
// Union-find over a 1024-entry parent/rank table in one synchronous RAM.
// ============================================================================
// Feed edges in ascending weight order; each edge returns one result with
// the accept flag, running total, edge count and completion flags. After
// reset and after every node_count write the table is swept back to
// identity with s_tready low. An ignored edge (tree already complete or an
// endpoint out of range) skips the table walk and goes straight to its
// result. A processed edge walks the chains from both endpoints to their
// roots and adds one more table write when a rank rises; each hop is one
// read of the table RAM, once while searching for the root and once more
// while rewriting the path to it. Path compression keeps the depths small.
// A finished result waits in the output register while the next edge runs.
module kruskal_edge_acceptor_top
    import ked_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration: node_count
    input  logic                      cfg_wr_en,
    input  logic [CFG_BITS-1:0]       cfg_wr_data,
    // Edge input
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // edge_from[9:0], edge_to[19:10],
                                                 // edge_weight[50:20], zero pad
    input  logic                      s_tlast,   // last_edge
    // Result output
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // total_weight[40:0],
                                                 // edges_taken[50:41], zero pad
    output logic [OUT_TUSER_BITS-1:0] m_tuser    // accepted[0], complete[1],
                                                 // impossible[2]
);

    tally_cmd_t              cmd;
    tally_stat_t             stat;
    logic                    ram_we;
    logic                    ram_re;
    logic [NODE_BITS-1:0]    ram_waddr;
    logic [NODE_BITS-1:0]    ram_raddr;
    entry_t                  ram_wdata;
    entry_t                  ram_rdata;
    logic [ENTRY_BITS-1:0]   ram_rdata_raw;
    logic [TOTAL_BITS-1:0]   total_weight;
    logic [NODE_BITS-1:0]    edges_taken;
    logic                    accepted;
    logic                    complete;
    logic                    impossible;

    assign ram_rdata = entry_t'(ram_rdata_raw);

    // Parent and rank table
    ked_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_NODES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    // Find, compress and union sequencer
    ked_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .edge_from   (s_tdata[NODE_BITS-1:0]),
        .edge_to     (s_tdata[2*NODE_BITS-1:NODE_BITS]),
        .edge_weight (s_tdata[2*NODE_BITS+WEIGHT_BITS-1:2*NODE_BITS]),
        .last_edge   (s_tlast),
        .stat        (stat),
        .cmd         (cmd),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // Totals and result register
    ked_tally u_tally (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .stat         (stat),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .total_weight (total_weight),
        .edges_taken  (edges_taken),
        .accepted     (accepted),
        .complete     (complete),
        .impossible   (impossible)
    );

    // Result packing
    assign m_tdata = {{(OUT_TDATA_BITS - TOTAL_BITS - NODE_BITS){1'b0}},
                      edges_taken, total_weight};
    assign m_tuser = {impossible, complete, accepted};

    // Checks
    a_cfg_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !s_tready
    ) else $error("edge transfer allowed right after node_count write");

    a_no_rw_collision: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr)
    ) else $error("table read and write hit the same entry");

    a_no_take_after_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.take |-> !stat.done
    ) else $error("edge taken after the tree was complete");

    a_result_from_load: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.load)
    ) else $error("result valid without a load");

endmodule
